### design/assert_macros.svh
// assertion helpers included by the row-scan core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// overlapping implication, checked outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rlmrs_pkg.sv
package rlmrs_pkg;

    // default geometry
    localparam int ROWS_DEF   = 8;
    localparam int PANELS_DEF = 2;

    // fixed field widths
    localparam int COL_W   = 8;
    localparam int ROW_W   = 3;
    localparam int CODE_W  = 3;

    // request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // colour codes
    localparam logic [CODE_W-1:0] COLOUR_BLANK    = 3'd0;
    localparam logic [CODE_W-1:0] COLOUR_BLUE_LO  = 3'd3;
    localparam logic [CODE_W-1:0] COLOUR_BLUE_HI  = 3'd4;
    localparam logic [CODE_W-1:0] COLOUR_GREEN_LO = 3'd5;

    typedef struct packed {
        logic              func;
        logic              panel;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  column;
        logic [CODE_W-1:0] colour;
    } in_item_t;

    typedef struct packed {
        logic             panel_out;
        logic [COL_W-1:0] red_bits_n;
        logic [COL_W-1:0] blue_bits_n;
        logic [COL_W-1:0] green_bits_n;
        logic [COL_W-1:0] row_select;
    } out_item_t;

    typedef struct packed {
        logic red;
        logic blue;
        logic green;
    } plane_sel_t;

    // which plane a colour code lights, none for blank
    function automatic plane_sel_t colour_planes(input logic [CODE_W-1:0] code);
        plane_sel_t sel;
        sel = '0;
        if (code == COLOUR_BLANK) begin
            sel = '0;
        end else if (code == COLOUR_BLUE_LO || code == COLOUR_BLUE_HI) begin
            sel.blue = 1'b1;
        end else if (code >= COLOUR_GREEN_LO) begin
            sel.green = 1'b1;
        end else begin
            sel.red = 1'b1;
        end
        return sel;
    endfunction

endpackage

### design/rgb_led_matrix_row_scan_core.sv
// Frame store and row-scan sequencer for PANELS RGB LED panels of ROWS rows by 8 columns.
// A write request clears one pixel in the red, blue and green planes and sets it in the plane
// its colour code names; a tick request returns the inverted plane bytes and one-hot row select
// of the panel's current scan row, then advances that row. Requests for a panel beyond PANELS,
// and writes to a row beyond ROWS, are dropped. One request is taken every clock cycle while the
// result side keeps up; a tick waits in the input register while an earlier frame is unread,
// and holds back the requests behind it. A tick's frame reaches the result port through the input
// register, then the result register; the store is flip-flops, read and updated in the same pass.
// Reset clears the store and the scan counters.
module rgb_led_matrix_row_scan_core
    import rlmrs_pkg::*;
#(
    parameter int ROWS   = ROWS_DEF,
    parameter int PANELS = PANELS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

`include "assert_macros.svh"

    localparam int ENTRIES = PANELS * ROWS;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // registers
    logic                           in_valid_reg;
    in_item_t                       in_reg;
    logic                           out_valid_reg, out_valid_next;
    out_item_t                      out_reg, out_next;
    logic [ENTRIES-1:0][COL_W-1:0]  red_reg, red_next;
    logic [ENTRIES-1:0][COL_W-1:0]  blue_reg, blue_next;
    logic [ENTRIES-1:0][COL_W-1:0]  green_reg, green_next;
    logic [PANELS-1:0][ROW_W-1:0]   scan_reg, scan_next;

    // decode
    logic       panel_ok;
    logic       row_ok;
    logic       is_tick;
    logic       out_free;
    logic       fire;
    logic       do_write;
    logic       do_tick;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [ROW_W-1:0] cur_row;
    logic [ROW_W-1:0] cur_eff;
    logic [ROW_W-1:0] row_inc;
    plane_sel_t       sel;

    // request qualification
    assign panel_ok = (int'(in_reg.panel) < PANELS);
    assign row_ok   = (int'(in_reg.row) < ROWS);
    assign is_tick  = (in_reg.func == FUNC_TICK);
    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && (out_free || !(is_tick && panel_ok));
    assign do_write = fire && !is_tick && panel_ok && row_ok;
    assign do_tick  = fire && is_tick && panel_ok;
    assign s_ready  = !in_valid_reg || fire;
    assign sel      = colour_planes(in_reg.colour);

    // current scan row of the addressed panel
    always_comb begin
        cur_row = '0;
        for (int p = 0; p < PANELS; p++) begin
            if (int'(in_reg.panel) == p) begin
                cur_row = scan_reg[p];
            end
        end
        cur_eff = (int'(cur_row) < ROWS) ? cur_row : '0;
        row_inc = (int'(cur_eff) + 1 < ROWS) ? ROW_W'(int'(cur_eff) + 1) : '0;
        wr_idx  = IDX_W'(int'(in_reg.panel) * ROWS + int'(in_reg.row));
        rd_idx  = IDX_W'(int'(in_reg.panel) * ROWS + int'(cur_eff));
    end

    // pixel update in all three planes
    always_comb begin
        red_next   = red_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        for (int e = 0; e < ENTRIES; e++) begin
            if (do_write && wr_idx == IDX_W'(e)) begin
                red_next[e][in_reg.column]   = sel.red;
                blue_next[e][in_reg.column]  = sel.blue;
                green_next[e][in_reg.column] = sel.green;
            end
        end
    end

    // scan counter advance
    always_comb begin
        scan_next = scan_reg;
        for (int p = 0; p < PANELS; p++) begin
            if (do_tick && int'(in_reg.panel) == p) begin
                scan_next[p] = row_inc;
            end
        end
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        if (do_tick) begin
            out_valid_next         = 1'b1;
            out_next.panel_out     = in_reg.panel;
            out_next.red_bits_n    = ~red_reg[rd_idx];
            out_next.blue_bits_n   = ~blue_reg[rd_idx];
            out_next.green_bits_n  = ~green_reg[rd_idx];
            out_next.row_select    = COL_W'(1) << cur_eff;
        end
    end

    // control and store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            blue_reg      <= '0;
            green_reg     <= '0;
            scan_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
            red_reg       <= red_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
            scan_reg      <= scan_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // checks
    `ASSERT_IMPL(a_row_sel_onehot, m_valid, $onehot(m_data.row_select), "row select not one-hot")
    `ASSERT_NEXT(a_tick_gives_frame, do_tick, m_valid, "tick produced no frame")
    `ASSERT_NEXT(a_write_keeps_scan, fire && !is_tick, $stable(scan_reg), "write moved scan row")
    `ASSERT_NEXT(a_held_request, in_valid_reg && !fire, in_valid_reg && $stable(in_reg),
        "stalled request lost")

endmodule
